// ----- rtl/wua_pkg.sv -----
// ----------------------------------------------------------------------------
// wua_pkg
// Shared types, codes and defaults of the wide unsigned arithmetic unit.
// ----------------------------------------------------------------------------
package wua_pkg;

	// default geometry
	localparam int WIDTH_DEF     = 256;
	localparam int WORD_BITS_DEF = 64;

	// width of the word fields on the ports
	localparam int XW = 64;

	// operation codes (unused codes behave as compare)
	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_MOD = 3'd4;
	localparam logic [2:0] FN_CMP = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_UNF = 2'd2;
	localparam logic [1:0] ST_DBZ = 2'd3;

	// ordering codes
	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	// input item
	typedef struct packed {
		logic [2:0]    func;
		logic [XW-1:0] a_word;
		logic [XW-1:0] b_word;
		logic          last_in;
	} alu_in_t;

	// result item
	typedef struct packed {
		logic [XW-1:0] result_word;
		logic [1:0]    word_index;
		logic          final_word;
		logic [1:0]    status;
		logic [1:0]    order;
	} alu_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic load_last;
		logic start;
		logic mul_step;
		logic div_step;
		logic finish;
		logic out_shift;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic b_zero;
		logic step_last;
		logic out_last;
	} dp_stat_t;

endpackage

// ----- rtl/wua_datapath.sv -----
// ----------------------------------------------------------------------------
// wua_datapath
// Operand registers, shared adder and subtractor, iteration and output
// counters of the wide unsigned arithmetic unit.
// ----------------------------------------------------------------------------
module wua_datapath import wua_pkg::*; #(
	parameter int WIDTH     = WIDTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  alu_in_t  in_data,
	output dp_stat_t stat,
	output alu_out_t out_data
);

	localparam int WORDS = WIDTH / WORD_BITS;
	localparam int LCW   = $clog2(WORDS + 1);
	localparam int OCW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SCW   = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q, b_q, r_q, rem_q;
	logic [LCW-1:0]   loaded_q;
	logic [OCW-1:0]   out_cnt_q;
	logic [SCW-1:0]   step_q;
	logic [2:0]       func_q;
	logic [1:0]       status_q, order_q;

	// shifted views used by the iterations
	logic [WIDTH-1:0] r_sh, rem_sh;
	logic             rem_out;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   minuend;
	logic [WIDTH+1:0] diff;
	logic             borrow, a_eq_b;

	assign r_sh    = {r_q[WIDTH-2:0], 1'b0};
	assign rem_sh  = {rem_q[WIDTH-2:0], a_q[WIDTH-1]};
	assign rem_out = rem_q[WIDTH-1];

	// shared adder: a + b at start, shifted product + a while multiplying
	assign sum = {1'b0, a_q} + {1'b0, (cmd.start ? b_q : r_sh)};

	// shared subtractor: a - b at start, partial remainder - b while dividing
	assign minuend = cmd.start ? {1'b0, a_q} : {rem_out, rem_sh};
	assign diff    = {1'b0, minuend} - {2'b00, b_q};
	assign borrow  = diff[WIDTH+1];
	assign a_eq_b  = (a_q == b_q);

	// operand loading and clearing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_q      <= '0;
			loaded_q <= '0;
		end else if (cmd.finish) begin
			a_q      <= '0;
			b_q      <= '0;
			loaded_q <= '0;
		end else if (cmd.load) begin
			for (int k = 0; k < WORDS; k++) begin
				if (loaded_q == LCW'(k)) begin
					a_q[k*WORD_BITS +: WORD_BITS] <= in_data.a_word[WORD_BITS-1:0];
					b_q[k*WORD_BITS +: WORD_BITS] <= in_data.b_word[WORD_BITS-1:0];
				end
			end
			if (loaded_q < LCW'(WORDS))
				loaded_q <= loaded_q + LCW'(1);
		end else if (cmd.mul_step) begin
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end else if (cmd.div_step) begin
			a_q <= {a_q[WIDTH-2:0], 1'b0};
		end
	end

	// operation code capture
	always_ff @(posedge clk) begin
		if (cmd.load && cmd.load_last)
			func_q <= in_data.func;
	end

	// result, remainder and status
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			r_q   <= '0;
			if (borrow)
				order_q <= ORD_LESS;
			else if (a_eq_b)
				order_q <= ORD_EQUAL;
			else
				order_q <= ORD_GREATER;
			status_q <= ST_OK;
			case (func_q)
				FN_ADD: begin
					r_q <= sum[WIDTH-1:0];
					if (sum[WIDTH])
						status_q <= ST_OVF;
				end
				FN_SUB: begin
					r_q <= diff[WIDTH-1:0];
					if (borrow)
						status_q <= ST_UNF;
				end
				FN_DIV, FN_MOD: begin
					if (stat.b_zero)
						status_q <= ST_DBZ;
				end
				default: begin
				end
			endcase
		end else if (cmd.mul_step) begin
			r_q <= b_q[WIDTH-1] ? sum[WIDTH-1:0] : r_sh;
			if (r_q[WIDTH-1] || (b_q[WIDTH-1] && sum[WIDTH]))
				status_q <= ST_OVF;
		end else if (cmd.div_step) begin
			rem_q <= borrow ? rem_sh : diff[WIDTH-1:0];
			r_q   <= {r_q[WIDTH-2:0], ~borrow};
		end else if (cmd.finish) begin
			if (status_q != ST_OK)
				r_q <= '0;
			else if (func_q == FN_MOD)
				r_q <= rem_q;
		end else if (cmd.out_shift) begin
			r_q <= r_q >> WORD_BITS;
		end
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (cmd.start)
			step_q <= SCW'(WIDTH - 1);
		else if (cmd.mul_step || cmd.div_step)
			step_q <= step_q - SCW'(1);
	end

	// output word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_cnt_q <= '0;
		else if (cmd.finish)
			out_cnt_q <= '0;
		else if (cmd.out_shift)
			out_cnt_q <= out_cnt_q + OCW'(1);
	end

	assign stat.is_mul    = (func_q == FN_MUL);
	assign stat.is_div    = (func_q == FN_DIV) || (func_q == FN_MOD);
	assign stat.b_zero    = (b_q == '0);
	assign stat.step_last = (step_q == '0);
	assign stat.out_last  = (out_cnt_q == OCW'(WORDS - 1));

	assign out_data.result_word = XW'(r_q[WORD_BITS-1:0]);
	assign out_data.word_index  = 2'(out_cnt_q);
	assign out_data.final_word  = stat.out_last;
	assign out_data.status      = status_q;
	assign out_data.order       = order_q;

	// an error always delivers zero words
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_shift && (status_q != ST_OK) |-> out_data.result_word == '0)
		else $error("nonzero result word with error status");

	// operands are cleared for the next operation
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (loaded_q == '0) && (a_q == '0) && (b_q == '0))
		else $error("operands not cleared after operation");

	// a new operation starts its output from the lowest word
	a_out_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_cnt_q == '0)
		else $error("output counter not rewound");

endmodule

// ----- rtl/wua_ctrl.sv -----
// ----------------------------------------------------------------------------
// wua_ctrl
// Sequencer of the wide unsigned arithmetic unit: operand loading,
// iteration, result cleanup and word-by-word output.
// ----------------------------------------------------------------------------
module wua_ctrl import wua_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     last_in,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_LOAD   = 6'b000001,
		S_START  = 6'b000010,
		S_MUL    = 6'b000100,
		S_DIV    = 6'b001000,
		S_FINISH = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   in_xfer, out_xfer;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_xfer && last_in)
					state_d = S_START;
			end
			S_START: begin
				if (stat.is_mul)
					state_d = S_MUL;
				else if (stat.is_div && !stat.b_zero)
					state_d = S_DIV;
				else
					state_d = S_FINISH;
			end
			S_MUL, S_DIV: begin
				if (stat.step_last)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_xfer && stat.out_last)
					state_d = S_LOAD;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	// datapath commands
	assign cmd.load      = in_xfer;
	assign cmd.load_last = last_in;
	assign cmd.start     = (state_q == S_START);
	assign cmd.mul_step  = (state_q == S_MUL);
	assign cmd.div_step  = (state_q == S_DIV);
	assign cmd.finish    = (state_q == S_FINISH);
	assign cmd.out_shift = out_xfer;

	// the two channels never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	// the last operand word starts the operation
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_in |=> cmd.start)
		else $error("operation did not start after last word");

	// the last result word reopens the input
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && stat.out_last |=> in_ready)
		else $error("input not reopened after last result word");

endmodule

// ----- rtl/wide_unsigned_alu.sv -----
// ----------------------------------------------------------------------------
// wide_unsigned_alu
// Wide unsigned add, subtract, multiply, divide, modulo and compare unit.
// ----------------------------------------------------------------------------
// Operands are loaded one word per input transfer, least significant first;
// words never loaded count as zero and the operation code is taken with the
// word marked last_in. After the last word the unit passes through a start
// state (compare, and the whole add or subtract), then, for multiply, divide
// or modulo, WIDTH iteration steps, one shift-add or restoring shift-subtract
// step per cycle through a single WIDTH-bit adder or subtractor (a divide by
// zero skips them), then a cleanup state, and finally emits WIDTH/WORD_BITS
// result words, one per output transfer. Input is not taken while a result
// is being delivered.
// ----------------------------------------------------------------------------
module wide_unsigned_alu import wua_pkg::*; #(
	parameter int WIDTH     = WIDTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  alu_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output alu_out_t out_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	wua_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_in   (in_data.last_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// operand and result datapath
	wua_datapath #(
		.WIDTH     (WIDTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
